// File: rtl/abm_pkg.sv
// ----------------------------------------------------------------------------
// abm_pkg: shared constants, types and helpers of the battery monitor
// Window size, sample width, register map and the command and status
// groups between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package abm_pkg;

   // window and sample geometry
   localparam int unsigned WINDOW      = 19;
   localparam int unsigned SAMPLE_BITS = 24;
   localparam int unsigned MID         = WINDOW / 2;
   localparam int unsigned ADDR_W      = $clog2(WINDOW);
   localparam int unsigned CNT_W       = $clog2(WINDOW + 1);

   // register and arithmetic widths
   localparam int unsigned REF_W    = 16;
   localparam int unsigned BOT_W    = 16;
   localparam int unsigned TOP_W    = 20;
   localparam int unsigned OFS_W    = 16;
   localparam int unsigned CODE_W   = 16;
   localparam int unsigned MV_W     = 20;
   localparam int unsigned SUM_W    = TOP_W + 1;
   localparam int unsigned PROD1_W  = CODE_W + REF_W;
   localparam int unsigned Q1_W     = 16;
   localparam int unsigned PROD2_W  = Q1_W + SUM_W;
   localparam int unsigned DIVCNT_W = $clog2(PROD2_W + 1);
   localparam int unsigned MV_SHIFT = 7;
   localparam int unsigned SCALED_W = PROD2_W - MV_SHIFT + 1;

   localparam logic [MV_W-1:0] MV_MAX = '1;

   // configuration port
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 20;

   localparam logic [CSR_IDX_W-1:0] CSR_REFERENCE = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_BOTTOM    = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_TOP       = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET    = CSR_IDX_W'(3);

   localparam logic [REF_W-1:0] REFERENCE_RST = REF_W'(2489);
   localparam logic [BOT_W-1:0] BOTTOM_RST    = BOT_W'(30);
   localparam logic [TOP_W-1:0] TOP_RST       = TOP_W'(20000);
   localparam logic [OFS_W-1:0] OFFSET_RST    = OFS_W'(100);

   // upper 16 bits of a sample, left aligned for samples narrower than 16
   function automatic logic [CODE_W-1:0] upper_sixteen(input logic [SAMPLE_BITS-1:0] v);
      logic [SAMPLE_BITS+CODE_W-1:0] w;
      w = {v, {CODE_W{1'b0}}};
      return w[SAMPLE_BITS+CODE_W-1 -: CODE_W];
   endfunction

   typedef struct packed {
      logic              ram_wr;
      logic [ADDR_W-1:0] ram_waddr;
      logic [ADDR_W-1:0] ram_raddr;
      logic              cand_load;
      logic              rank_clear;
      logic              rank_acc;
      logic              median_load;
      logic              mul1;
      logic              div65;
      logic              mul2;
      logic              div_init;
      logic              div_step;
      logic              out_load;
   } abm_cmd_type;

   typedef struct packed {
      logic is_median;
      logic out_full;
   } abm_stat_type;

endpackage

`default_nettype wire

// File: rtl/abm_if.sv
// ----------------------------------------------------------------------------
// abm_if: request and response channels of the battery monitor
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface abm_req_if import abm_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] sample_word;

   modport source (output valid, output sample_word, input ready);
   modport sink   (input valid, input sample_word, output ready);
endinterface

interface abm_rsp_if import abm_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] median_code;
   logic [MV_W-1:0]        battery_mv;

   modport source (output valid, output median_code, output battery_mv, input ready);
   modport sink   (input valid, input median_code, input battery_mv, output ready);
endinterface

`default_nettype wire

// File: rtl/abm_ram.sv
// ----------------------------------------------------------------------------
// abm_ram: generic single write, single read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module abm_ram #(
   parameter int unsigned WIDTH = 24,
   parameter int unsigned DEPTH = 19,
   localparam int unsigned AW   = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// File: rtl/abm_ctrl.sv
// ----------------------------------------------------------------------------
// abm_ctrl: sequencer of the battery monitor
// Fills the window, runs the rank count per candidate, then steps the
// scaling datapath and the divider and hands the result to the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module abm_ctrl import abm_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   output abm_cmd_type       cmd,
   input  wire abm_stat_type stat
);

   typedef enum logic [10:0] {
      S_FILL     = 11'b000_0000_0001,
      S_CAND_RD  = 11'b000_0000_0010,
      S_CAND_LD  = 11'b000_0000_0100,
      S_SWEEP    = 11'b000_0000_1000,
      S_JUDGE    = 11'b000_0001_0000,
      S_MUL1     = 11'b000_0010_0000,
      S_DIV65    = 11'b000_0100_0000,
      S_MUL2     = 11'b000_1000_0000,
      S_DIV_INIT = 11'b001_0000_0000,
      S_DIV_STEP = 11'b010_0000_0000,
      S_OUT      = 11'b100_0000_0000
   } state_type;

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    sample_cnt_ff, sample_cnt_in;
   logic [ADDR_W-1:0]   cand_ff, cand_in;
   logic [CNT_W-1:0]    sweep_ff, sweep_in;
   logic [DIVCNT_W-1:0] div_cnt_ff, div_cnt_in;

   always_comb begin
      state_in      = state_ff;
      sample_cnt_in = sample_cnt_ff;
      cand_in       = cand_ff;
      sweep_in      = sweep_ff;
      div_cnt_in    = div_cnt_ff;
      req_ready     = 1'b0;
      cmd           = '0;
      cmd.ram_waddr = sample_cnt_ff[ADDR_W-1:0];

      unique case (state_ff)
         S_FILL: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.ram_wr = 1'b1;
               if (sample_cnt_ff == CNT_W'(WINDOW - 1)) begin
                  sample_cnt_in = '0;
                  cand_in       = '0;
                  state_in      = S_CAND_RD;
               end else begin
                  sample_cnt_in = sample_cnt_ff + 1'b1;
               end
            end
         end
         S_CAND_RD: begin
            cmd.ram_raddr = cand_ff;
            state_in      = S_CAND_LD;
         end
         S_CAND_LD: begin
            cmd.cand_load  = 1'b1;
            cmd.rank_clear = 1'b1;
            cmd.ram_raddr  = '0;
            sweep_in       = CNT_W'(1);
            state_in       = S_SWEEP;
         end
         S_SWEEP: begin
            // compare the entry read last cycle, issue the next read
            cmd.rank_acc = 1'b1;
            if (sweep_ff == CNT_W'(WINDOW)) begin
               state_in = S_JUDGE;
            end else begin
               cmd.ram_raddr = sweep_ff[ADDR_W-1:0];
               sweep_in      = sweep_ff + 1'b1;
            end
         end
         S_JUDGE: begin
            if (stat.is_median) begin
               cmd.median_load = 1'b1;
               state_in        = S_MUL1;
            end else begin
               cand_in  = cand_ff + 1'b1;
               state_in = S_CAND_RD;
            end
         end
         S_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = S_DIV65;
         end
         S_DIV65: begin
            cmd.div65 = 1'b1;
            state_in  = S_MUL2;
         end
         S_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = S_DIV_INIT;
         end
         S_DIV_INIT: begin
            cmd.div_init = 1'b1;
            div_cnt_in   = '0;
            state_in     = S_DIV_STEP;
         end
         S_DIV_STEP: begin
            cmd.div_step = 1'b1;
            if (div_cnt_ff == DIVCNT_W'(PROD2_W - 1)) begin
               state_in = S_OUT;
            end else begin
               div_cnt_in = div_cnt_ff + 1'b1;
            end
         end
         S_OUT: begin
            // wait for the output register to drain
            if (!stat.out_full) begin
               cmd.out_load = 1'b1;
               state_in     = S_FILL;
            end
         end
         default: begin
            state_in = S_FILL;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_FILL;
         sample_cnt_ff <= '0;
         cand_ff       <= '0;
         sweep_ff      <= '0;
         div_cnt_ff    <= '0;
      end else begin
         state_ff      <= state_in;
         sample_cnt_ff <= sample_cnt_in;
         cand_ff       <= cand_in;
         sweep_ff      <= sweep_in;
         div_cnt_ff    <= div_cnt_in;
      end
   end

   a_out_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !stat.out_full)
      else $error("result loaded over a pending transfer");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      sample_cnt_ff < CNT_W'(WINDOW))
      else $error("window fill count out of range");

   a_median_found: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_JUDGE) && !stat.is_median |-> cand_ff != ADDR_W'(WINDOW - 1))
      else $error("no candidate ranked as median");

   a_judge_to_scale: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_JUDGE) && stat.is_median |=> state_ff == S_MUL1)
      else $error("median found but scaling not started");

endmodule

`default_nettype wire

// File: rtl/abm_dp.sv
// ----------------------------------------------------------------------------
// abm_dp: datapath of the battery monitor
// Window memory, rank counters, millivolt scaling with a bit-serial divider,
// configuration registers and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module abm_dp import abm_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic [SAMPLE_BITS-1:0] sample_word,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic      [SAMPLE_BITS-1:0] median_code,
   output logic      [MV_W-1:0]        battery_mv,
   input  wire abm_cmd_type            cmd,
   output abm_stat_type                stat
);

   logic [REF_W-1:0] reference_ff;
   logic [BOT_W-1:0] bottom_ff;
   logic [TOP_W-1:0] top_ff;
   logic [OFS_W-1:0] offset_ff;

   logic [SAMPLE_BITS-1:0] rd_data;
   logic [SAMPLE_BITS-1:0] cand_val_ff;
   logic [SAMPLE_BITS-1:0] median_ff;
   logic [CNT_W-1:0]       less_ff;
   logic [CNT_W-1:0]       eq_ff;
   logic [CNT_W:0]         le_sum;

   logic [PROD1_W-1:0] prod1_ff;
   logic [PROD1_W:0]   q1_sum;
   logic [Q1_W-1:0]    q1_ff;
   logic [SUM_W-1:0]   sum_ff;
   logic [PROD2_W-1:0] prod2_ff;

   logic [BOT_W:0]     rem_ff;
   logic [PROD2_W-1:0] quo_ff;
   logic [BOT_W:0]     rem_shift;
   logic [BOT_W+1:0]   rem_diff;

   logic [SCALED_W-1:0] scaled;
   logic [MV_W-1:0]     mv_sat;
   logic                out_valid_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         reference_ff <= REFERENCE_RST;
         bottom_ff    <= BOTTOM_RST;
         top_ff       <= TOP_RST;
         offset_ff    <= OFFSET_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_REFERENCE: reference_ff <= csr_wdata[REF_W-1:0];
            CSR_BOTTOM:    bottom_ff    <= csr_wdata[BOT_W-1:0];
            CSR_TOP:       top_ff       <= csr_wdata[TOP_W-1:0];
            CSR_OFFSET:    offset_ff    <= csr_wdata[OFS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   abm_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (WINDOW)
   ) u_window (
      .clock   (clock),
      .wr_en   (cmd.ram_wr),
      .wr_addr (cmd.ram_waddr),
      .wr_data (sample_word),
      .rd_addr (cmd.ram_raddr),
      .rd_data (rd_data)
   );

   // rank of the candidate: entries below it and entries equal to it
   assign le_sum         = {1'b0, less_ff} + {1'b0, eq_ff};
   assign stat.is_median = (less_ff <= CNT_W'(MID)) && (le_sum > (CNT_W + 1)'(MID));

   always_ff @(posedge clock) begin
      if (cmd.cand_load) begin
         cand_val_ff <= rd_data;
      end
      if (cmd.rank_clear) begin
         less_ff <= '0;
         eq_ff   <= '0;
      end else if (cmd.rank_acc) begin
         if (rd_data < cand_val_ff) begin
            less_ff <= less_ff + 1'b1;
         end
         if (rd_data == cand_val_ff) begin
            eq_ff <= eq_ff + 1'b1;
         end
      end
      if (cmd.median_load) begin
         median_ff <= cand_val_ff;
      end
   end

   // x / 65535 as (x + (x >> 16) + 1) >> 16, exact for a 16 by 16 product
   assign q1_sum = {1'b0, prod1_ff} + (PROD1_W + 1)'(prod1_ff[PROD1_W-1:Q1_W])
                   + (PROD1_W + 1)'(1);

   always_ff @(posedge clock) begin
      if (cmd.mul1) begin
         prod1_ff <= upper_sixteen(median_ff) * reference_ff;
      end
      if (cmd.div65) begin
         q1_ff  <= q1_sum[PROD1_W-1:Q1_W];
         sum_ff <= {1'b0, top_ff} + SUM_W'(bottom_ff);
      end
      if (cmd.mul2) begin
         prod2_ff <= q1_ff * sum_ff;
      end
   end

   // restoring divider, one quotient bit per step
   assign rem_shift = {rem_ff[BOT_W-1:0], quo_ff[PROD2_W-1]};
   assign rem_diff  = {1'b0, rem_shift} - {2'b00, bottom_ff};

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         rem_ff <= '0;
         quo_ff <= prod2_ff;
      end else if (cmd.div_step) begin
         if (!rem_diff[BOT_W+1]) begin
            rem_ff <= rem_diff[BOT_W:0];
            quo_ff <= {quo_ff[PROD2_W-2:0], 1'b1};
         end else begin
            rem_ff <= rem_shift;
            quo_ff <= {quo_ff[PROD2_W-2:0], 1'b0};
         end
      end
   end

   assign scaled = {1'b0, quo_ff[PROD2_W-1:MV_SHIFT]} + SCALED_W'(offset_ff);

   always_comb begin
      if (bottom_ff == '0) begin
         mv_sat = MV_MAX;
      end else if (scaled > SCALED_W'(MV_MAX)) begin
         mv_sat = MV_MAX;
      end else begin
         mv_sat = scaled[MV_W-1:0];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         median_code <= median_ff;
         battery_mv  <= mv_sat;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign stat.out_full = out_valid_ff;

endmodule

`default_nettype wire

// File: rtl/adc_median_battery_monitor_unit.sv
// ----------------------------------------------------------------------------
// adc_median_battery_monitor_unit: median filter and battery voltage scaler
// Collects a window of converter samples, picks the median and converts its
// upper 16 bits into a saturated millivolt figure.
//
//   channel   direction  transfer when             payload
//   req_chan  in         valid & ready             sample_word
//   rsp_chan  out        valid & ready             median_code, battery_mv
//   csr_*     in         csr_wr_en                 csr_index, csr_wdata
//
// The unit is ready for a sample throughout the window fill.
// After the last sample of a window the median search reads one candidate at
// a time (at most 19 candidates) and compares it with every window entry in
// turn, bound by the single read port of the window memory; scaling then
// follows, mostly in the one-bit-per-cycle divider. No sample is taken then.
// The result sits in an output register; the next window fills meanwhile, and
// a result waits in the sequencer only while the previous one is not taken.
// Synchronous reset clears the fill count and loads the default registers.
// ----------------------------------------------------------------------------
`default_nettype none

module adc_median_battery_monitor_unit import abm_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   abm_req_if.sink                    req_chan,
   abm_rsp_if.source                  rsp_chan,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   abm_cmd_type  cmd;
   abm_stat_type stat;

   abm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   abm_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .sample_word (req_chan.sample_word),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready),
      .median_code (rsp_chan.median_code),
      .battery_mv  (rsp_chan.battery_mv),
      .cmd         (cmd),
      .stat        (stat)
   );

endmodule

`default_nettype wire
